/* hw/rtl/qtq_pkg.sv */
`timescale 1ns / 1ps

package qtq_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned QUAL_W        = 7;
  localparam int unsigned SCALE_W       = 13;
  localparam int unsigned VAL_W         = 8;
  localparam int unsigned BASE_W        = 7;
  localparam int unsigned DIVISOR_W     = 6;
  localparam int unsigned SUM_W         = 20;
  localparam int unsigned SUM_LIM_W     = 15;
  localparam int unsigned PROD_W        = SUM_LIM_W + SCALE_W;

  localparam logic [QUAL_W-1:0]  QUAL_SPLIT  = QUAL_W'(50);
  localparam logic [QUAL_W-1:0]  QUAL_MAX    = QUAL_W'(99);
  localparam logic [QUAL_W-1:0]  QUAL_MIN    = QUAL_W'(1);
  localparam logic [SCALE_W-1:0] DIV_NUM     = SCALE_W'(5000);
  localparam logic [SCALE_W-1:0] SCALE_BASE  = SCALE_W'(200);
  localparam logic [SUM_W-1:0]   ROUND_BIAS  = SUM_W'(50);
  localparam logic [SUM_W-1:0]   SAT_LIMIT   = SUM_W'(25600);
  localparam logic [SCALE_W-1:0] RECIP       = SCALE_W'(5243);
  localparam int unsigned        RECIP_SHIFT = 19;
  localparam logic [VAL_W-1:0]   VAL_MIN     = VAL_W'(1);
  localparam logic [VAL_W-1:0]   VAL_MAX     = VAL_W'(255);
  localparam logic [IDX_W-1:0]   LAST_IDX    = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [BASE_W-1:0] LUMA_TBL [TABLE_ENTRIES] = '{
    7'd16, 7'd11, 7'd10, 7'd16, 7'd24, 7'd40, 7'd51, 7'd61,
    7'd12, 7'd12, 7'd14, 7'd19, 7'd26, 7'd58, 7'd60, 7'd55,
    7'd14, 7'd13, 7'd16, 7'd24, 7'd40, 7'd57, 7'd69, 7'd56,
    7'd14, 7'd17, 7'd22, 7'd29, 7'd51, 7'd87, 7'd80, 7'd62,
    7'd18, 7'd22, 7'd37, 7'd56, 7'd68, 7'd109, 7'd103, 7'd77,
    7'd24, 7'd35, 7'd55, 7'd64, 7'd81, 7'd104, 7'd113, 7'd92,
    7'd49, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
    7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99
  };

  localparam logic [BASE_W-1:0] CHROMA_TBL [TABLE_ENTRIES] = '{
    7'd17, 7'd18, 7'd24, 7'd47, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd18, 7'd21, 7'd26, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd24, 7'd26, 7'd56, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd47, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99
  };

  typedef struct packed {
    logic [VAL_W-1:0] luma;
    logic [VAL_W-1:0] chroma;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } wr_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    entry_t           data;
  } out_t;

endpackage

/* hw/rtl/qtq_ram.sv */
`timescale 1ns / 1ps

module qtq_ram #(
  parameter int unsigned DATA_W = qtq_pkg::ENTRY_W,
  parameter int unsigned DEPTH  = qtq_pkg::TABLE_ENTRIES,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/qtq_div.sv */
`timescale 1ns / 1ps

module qtq_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [qtq_pkg::DIVISOR_W-1:0]  divisor_i,
  output logic                           done_o,
  output logic [qtq_pkg::SCALE_W-1:0]    quot_o
);

  import qtq_pkg::*;

  localparam int unsigned CNT_W = $clog2(SCALE_W);

  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [DIVISOR_W-1:0] dvs_q, dvs_d;
  logic [SCALE_W-1:0]   quot_q, quot_d;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;

  // one quotient bit per cycle, msb first
  always_comb begin
    shifted = {rem_q, DIV_NUM[cnt_q]};
    fits    = shifted >= {1'b0, dvs_q};
    diff    = shifted - {1'b0, dvs_q};
    run_d   = run_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    quot_d  = quot_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CNT_W'(SCALE_W - 1);
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (run_q) begin
      rem_d  = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quot_d = {quot_q[SCALE_W-2:0], fits};
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

/* hw/rtl/qtq_scale.sv */
`timescale 1ns / 1ps

module qtq_scale (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [qtq_pkg::IDX_W-1:0]    idx_i,
  input  logic [qtq_pkg::SCALE_W-1:0]  scale_i,
  output qtq_pkg::wr_t                 wr_o
);

  import qtq_pkg::*;

  logic             v1_q, v2_q;
  logic [IDX_W-1:0] idx1_q, idx2_q;
  logic [SUM_W-1:0] l_sum_d, c_sum_d, l_sum_q, c_sum_q;
  logic [PROD_W-1:0] l_prod, c_prod;
  logic             l_sat_q, c_sat_q;
  logic [VAL_W-1:0] l_quo_q, c_quo_q;

  function automatic logic [VAL_W-1:0] clamp_val(input logic sat, input logic [VAL_W-1:0] q);
    logic [VAL_W-1:0] r;
    r = q;
    if (sat) begin
      r = VAL_MAX;
    end else if (q < VAL_MIN) begin
      r = VAL_MIN;
    end
    return r;
  endfunction

  // base times scale plus rounding bias
  assign l_sum_d = SUM_W'(LUMA_TBL[idx_i]) * SUM_W'(scale_i) + ROUND_BIAS;
  assign c_sum_d = SUM_W'(CHROMA_TBL[idx_i]) * SUM_W'(scale_i) + ROUND_BIAS;

  // divide by 100 via reciprocal, exact below the saturation limit
  assign l_prod = PROD_W'(l_sum_q[SUM_LIM_W-1:0]) * PROD_W'(RECIP);
  assign c_prod = PROD_W'(c_sum_q[SUM_LIM_W-1:0]) * PROD_W'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q  <= idx_i;
    l_sum_q <= l_sum_d;
    c_sum_q <= c_sum_d;
    idx2_q  <= idx1_q;
    l_sat_q <= l_sum_q >= SAT_LIMIT;
    c_sat_q <= c_sum_q >= SAT_LIMIT;
    l_quo_q <= l_prod[RECIP_SHIFT +: VAL_W];
    c_quo_q <= c_prod[RECIP_SHIFT +: VAL_W];
  end

  assign wr_o.en          = v2_q;
  assign wr_o.addr        = idx2_q;
  assign wr_o.data.luma   = clamp_val(l_sat_q, l_quo_q);
  assign wr_o.data.chroma = clamp_val(c_sat_q, c_quo_q);

endmodule

/* hw/rtl/jpeg_quant_table_from_quality.sv */
`timescale 1ns / 1ps

// quality to quantizer table generator
// input channel: one request carries quality_i, taken when in_valid_i is high
// and in_stall_o is low; in_stall_o stays high from acceptance until the last
// entry of the run has been taken on the output side
// output channel: 64 requests per quality, entry_index_o 0..63 in table order,
// last_entry_o high on entry 63; held while out_stall_i is high
// path: a quality of 50 and up passes the state register, the scale stages,
// the memory write, the memory read and the output buffer before entry 0 is shown;
// below 50 the scale first comes from a bit-serial divider
// throughput: one entry per cycle while unstalled, set by the one entry per cycle
// write and read ports of the result memory; a stalled output stops reads from
// the memory once the output buffer and the read in flight hold two entries;
// the two-entry output buffer keeps the full rate across stall edges
// reset: returns to idle with no run pending; memory content is not cleared

module jpeg_quant_table_from_quality (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [qtq_pkg::QUAL_W-1:0]  quality_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [qtq_pkg::IDX_W-1:0]   entry_index_o,
  output logic [qtq_pkg::VAL_W-1:0]   luma_value_o,
  output logic [qtq_pkg::VAL_W-1:0]   chroma_value_o,
  output logic                        last_entry_o
);

  import qtq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [SCALE_W-1:0] scale_q, scale_d;
  logic [IDX_W:0]     gen_cnt_q, gen_cnt_d;
  logic [IDX_W:0]     wr_cnt_q, wr_cnt_d;
  logic [IDX_W:0]     rd_ptr_q, rd_ptr_d;
  logic               rd_pend_q;
  logic [IDX_W-1:0]   rd_idx_q;
  logic [1:0]         ob_cnt_q, ob_cnt_d;
  out_t               ob_q [2];
  out_t               ob_d [2];
  logic [1:0]         ob_after;

  logic               accept;
  logic               pop;
  logic               rd_issue;
  logic               gen_valid;
  logic               div_start;
  logic               div_done;
  logic [SCALE_W-1:0] div_quot;
  logic [QUAL_W-1:0]  factor;
  logic               low_quality;
  logic               run_end;
  wr_t                wr;
  entry_t             rdata;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = state_q != ST_IDLE;
  assign low_quality = quality_i < QUAL_SPLIT;
  assign div_start   = accept && low_quality;
  assign pop         = (ob_cnt_q != '0) && !out_stall_i;
  assign run_end     = pop && (ob_q[0].idx == LAST_IDX);
  assign gen_valid   = (state_q == ST_RUN) && !gen_cnt_q[IDX_W];

  always_comb begin
    factor = quality_i;
    if (quality_i < QUAL_MIN) begin
      factor = QUAL_MIN;
    end else if (quality_i > QUAL_MAX) begin
      factor = QUAL_MAX;
    end
  end

  // read only entries already written; keep buffer plus in-flight read within two
  assign rd_issue = (state_q == ST_RUN) && (rd_ptr_q < wr_cnt_q) &&
                    (({1'b0, ob_cnt_q} + {2'b0, rd_pend_q}) <= ({2'b0, pop} + 3'd1));

  always_comb begin
    state_d   = state_q;
    scale_d   = scale_q;
    gen_cnt_d = gen_cnt_q;
    wr_cnt_d  = wr_cnt_q;
    rd_ptr_d  = rd_ptr_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          gen_cnt_d = '0;
          wr_cnt_d  = '0;
          rd_ptr_d  = '0;
          if (low_quality) begin
            state_d = ST_DIV;
          end else begin
            scale_d = SCALE_BASE - SCALE_W'({factor, 1'b0});
            state_d = ST_RUN;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          scale_d = div_quot;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (gen_valid) begin
          gen_cnt_d = gen_cnt_q + (IDX_W + 1)'(1);
        end
        if (wr.en) begin
          wr_cnt_d = wr_cnt_q + (IDX_W + 1)'(1);
        end
        if (rd_issue) begin
          rd_ptr_d = rd_ptr_q + (IDX_W + 1)'(1);
        end
        if (run_end) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // two-entry output buffer, head in slot 0
  always_comb begin
    ob_d[0]  = ob_q[0];
    ob_d[1]  = ob_q[1];
    ob_after = ob_cnt_q - {1'b0, pop};
    if (pop) begin
      ob_d[0] = ob_q[1];
    end
    if (rd_pend_q) begin
      ob_d[ob_after[0]] = '{idx: rd_idx_q, data: rdata};
    end
    ob_cnt_d = ob_after + {1'b0, rd_pend_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      scale_q   <= '0;
      gen_cnt_q <= '0;
      wr_cnt_q  <= '0;
      rd_ptr_q  <= '0;
      rd_pend_q <= 1'b0;
      ob_cnt_q  <= '0;
    end else begin
      state_q   <= state_d;
      scale_q   <= scale_d;
      gen_cnt_q <= gen_cnt_d;
      wr_cnt_q  <= wr_cnt_d;
      rd_ptr_q  <= rd_ptr_d;
      rd_pend_q <= rd_issue;
      ob_cnt_q  <= ob_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_ptr_q[IDX_W-1:0];
    ob_q[0]  <= ob_d[0];
    ob_q[1]  <= ob_d[1];
  end

  qtq_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (factor[DIVISOR_W-1:0]),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  qtq_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (gen_valid),
    .idx_i   (gen_cnt_q[IDX_W-1:0]),
    .scale_i (scale_q),
    .wr_o    (wr)
  );

  qtq_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (rd_issue),
    .raddr_i (rd_ptr_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  assign out_valid_o    = ob_cnt_q != '0;
  assign entry_index_o  = ob_q[0].idx;
  assign luma_value_o   = ob_q[0].data.luma;
  assign chroma_value_o = ob_q[0].data.chroma;
  assign last_entry_o   = ob_q[0].idx == LAST_IDX;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_ptr_q <= wr_cnt_q)
    else $error("read pointer passed written entries");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, ob_cnt_q} + {2'b0, rd_pend_q}) <= 3'd2)
    else $error("output buffer overcommitted");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ob_cnt_q != '0) |-> (state_q == ST_RUN))
    else $error("result shown outside a run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_end |=> (state_q == ST_IDLE) && (ob_cnt_q == '0) && !rd_pend_q)
    else $error("run ended with results left");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> (wr.addr == wr_cnt_q[IDX_W-1:0]))
    else $error("memory written out of order");

endmodule

/* tb/sv/jpeg_quant_table_from_quality_tb.sv */
`timescale 1ns / 1ps

module jpeg_quant_table_from_quality_tb;
  import qtq_pkg::*;

  localparam int unsigned DIRECTED_ROWS = 16;
  localparam int unsigned RANDOM_ITEMS  = 254;
  localparam int unsigned IDLE_PCT      = 34;
  localparam int unsigned CALM_FIRST    = 60;
  localparam int unsigned CALM_LAST     = 100;
  localparam int unsigned PAUSE_ITEM    = 150;
  localparam int unsigned HOLD_START    = 3000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned DRAIN_CYCLES  = 100;

  typedef enum logic [1:0] {
    EXP_PREDICT,
    EXP_ALL_MAX,
    EXP_BASE
  } exp_mode_e;

  typedef struct packed {
    exp_mode_e         mode;
    logic [QUAL_W-1:0] quality;
  } directed_row_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] luma;
    logic [VAL_W-1:0] chroma;
    logic             last;
  } quant_entry_t;

  localparam logic [VAL_W-1:0] LUMA_K1 [TABLE_ENTRIES] = '{
    8'd16, 8'd11, 8'd10, 8'd16, 8'd24, 8'd40, 8'd51, 8'd61,
    8'd12, 8'd12, 8'd14, 8'd19, 8'd26, 8'd58, 8'd60, 8'd55,
    8'd14, 8'd13, 8'd16, 8'd24, 8'd40, 8'd57, 8'd69, 8'd56,
    8'd14, 8'd17, 8'd22, 8'd29, 8'd51, 8'd87, 8'd80, 8'd62,
    8'd18, 8'd22, 8'd37, 8'd56, 8'd68, 8'd109, 8'd103, 8'd77,
    8'd24, 8'd35, 8'd55, 8'd64, 8'd81, 8'd104, 8'd113, 8'd92,
    8'd49, 8'd64, 8'd78, 8'd87, 8'd103, 8'd121, 8'd120, 8'd101,
    8'd72, 8'd92, 8'd95, 8'd98, 8'd112, 8'd100, 8'd103, 8'd99
  };

  localparam logic [VAL_W-1:0] CHROMA_K2 [TABLE_ENTRIES] = '{
    8'd17, 8'd18, 8'd24, 8'd47, 8'd99, 8'd99, 8'd99, 8'd99,
    8'd18, 8'd21, 8'd26, 8'd66, 8'd99, 8'd99, 8'd99, 8'd99,
    8'd24, 8'd26, 8'd56, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
    8'd47, 8'd66, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
    8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
    8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
    8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
    8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99
  };

  // quality 0 and 1 saturate every entry, quality 50 gives the base tables
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{EXP_ALL_MAX, 7'd0},
    '{EXP_ALL_MAX, 7'd1},
    '{EXP_BASE,    7'd50},
    '{EXP_PREDICT, 7'd127},
    '{EXP_PREDICT, 7'd99},
    '{EXP_PREDICT, 7'd100},
    '{EXP_PREDICT, 7'd2},
    '{EXP_PREDICT, 7'd49},
    '{EXP_PREDICT, 7'd51},
    '{EXP_PREDICT, 7'd98},
    '{EXP_PREDICT, 7'd25},
    '{EXP_PREDICT, 7'd75},
    '{EXP_PREDICT, 7'd85},
    '{EXP_PREDICT, 7'd42},
    '{EXP_PREDICT, 7'd10},
    '{EXP_PREDICT, 7'd64}
  };

  localparam logic [QUAL_W-1:0] QUALITY_EDGES [8] = '{
    7'd0, 7'd1, 7'd49, 7'd50, 7'd51, 7'd98, 7'd99, 7'd127
  };

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [QUAL_W-1:0] quality_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [IDX_W-1:0]  entry_index_o;
  logic [VAL_W-1:0]  luma_value_o;
  logic [VAL_W-1:0]  chroma_value_o;
  logic              last_entry_o;

  quant_entry_t quant_entries_due [$];
  int unsigned  mismatch_count = 0;
  logic         calm_stretch;

  jpeg_quant_table_from_quality u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .quality_i      (quality_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .entry_index_o  (entry_index_o),
    .luma_value_o   (luma_value_o),
    .chroma_value_o (chroma_value_o),
    .last_entry_o   (last_entry_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [SCALE_W-1:0] quant_scale(input logic [QUAL_W-1:0] q);
    int unsigned factor;
    factor = q;
    if (factor < 1) factor = 1;
    if (factor > 99) factor = 99;
    if (q < 50) return SCALE_W'(5000 / factor);
    return SCALE_W'(200 - 2 * factor);
  endfunction

  function automatic logic [VAL_W-1:0] scaled_quantizer(input logic [VAL_W-1:0] base,
                                                        input logic [SCALE_W-1:0] scale);
    int unsigned v;
    v = (base * scale + 32'd50) / 32'd100;
    if (v < 1) v = 1;
    if (v > 255) v = 255;
    return VAL_W'(v);
  endfunction

  task automatic queue_quant_table(input logic [QUAL_W-1:0] q, input exp_mode_e mode);
    logic [SCALE_W-1:0] scale;
    quant_entry_t       e;
    scale = quant_scale(q);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      e.idx  = IDX_W'(i);
      e.last = (i == TABLE_ENTRIES - 1);
      case (mode)
        EXP_ALL_MAX: begin
          e.luma   = VAL_MAX;
          e.chroma = VAL_MAX;
        end
        EXP_BASE: begin
          e.luma   = LUMA_K1[i];
          e.chroma = CHROMA_K2[i];
        end
        default: begin
          e.luma   = scaled_quantizer(LUMA_K1[i], scale);
          e.chroma = scaled_quantizer(CHROMA_K2[i], scale);
        end
      endcase
      quant_entries_due = {quant_entries_due, e};
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // valid stays high after acceptance until the next call drives it
  task automatic offer_quality(input logic [QUAL_W-1:0] q, input exp_mode_e mode);
    while (!calm_stretch && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      quality_i  <= QUAL_W'($urandom_range(127));
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    quality_i  <= q;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    queue_quant_table(q, mode);
  endtask

  task automatic wait_all_entries();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (quant_entries_due.size() != 0);
  endtask

  initial begin
    int unsigned       pick;
    logic [QUAL_W-1:0] q;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    quality_i    <= '0;
    calm_stretch <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      offer_quality(DIRECTED[r].quality, DIRECTED[r].mode);
    end
    wait_all_entries();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm_stretch <= (n >= CALM_FIRST && n < CALM_LAST);
      if (n == PAUSE_ITEM) wait_all_entries();
      pick = $urandom_range(99);
      if (pick < 60) q = QUAL_W'($urandom_range(127));
      else if (pick < 80) q = QUALITY_EDGES[$urandom_range(7)];
      else q = QUAL_W'($urandom_range(60, 40));
      offer_quality(q, EXP_PREDICT);
    end
    wait_all_entries();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS jpeg_quant_table_from_quality");
    end else begin
      $display("FAIL jpeg_quant_table_from_quality");
    end
    $finish;
  end

  // receiver: random stalls except in the calm stretch, one long hold-off
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= HOLD_START && cycle_count < HOLD_START + HOLD_CYCLES) begin
        out_stall_i <= 1'b1;
      end else if (calm_stretch) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    quant_entry_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (quant_entries_due.size() == 0) begin
        report_mismatch($sformatf("entry %0d with no request outstanding", entry_index_o));
      end else begin
        want = quant_entries_due.pop_front();
        if (entry_index_o !== want.idx) begin
          report_mismatch($sformatf("entry_index got %0d expected %0d",
                                    entry_index_o, want.idx));
        end
        if (luma_value_o !== want.luma) begin
          report_mismatch($sformatf("luma entry %0d got %0d expected %0d",
                                    want.idx, luma_value_o, want.luma));
        end
        if (chroma_value_o !== want.chroma) begin
          report_mismatch($sformatf("chroma entry %0d got %0d expected %0d",
                                    want.idx, chroma_value_o, want.chroma));
        end
        if (last_entry_o !== want.last) begin
          report_mismatch($sformatf("last_entry entry %0d got %0b expected %0b",
                                    want.idx, last_entry_o, want.last));
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL jpeg_quant_table_from_quality");
    $finish;
  end

endmodule
